// ----- src/hrfs_pkg.sv -----
// ----------------------------------------------------------------------------
// hrfs_pkg
// Shared types and constants of the heart-rate to fan-speed block.
// ----------------------------------------------------------------------------
package hrfs_pkg;

    // Depth of the ring of recent samples.
    localparam int SMOOTH_DEPTH = 8;

    localparam int RATE_W  = 9;
    localparam int SPEED_W = 7;
    localparam int IDX_W   = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
    localparam int CNT_W   = $clog2(SMOOTH_DEPTH + 1);
    localparam int SUM_W   = RATE_W + $clog2(SMOOTH_DEPTH) + 1;

    // Shared divider: the dividend covers both the rounded ring sum and the
    // speed product, the divisor covers both the fill count and the span.
    localparam int DIV_W     = 16;
    localparam int DVS_W     = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(100);
    localparam logic [SPEED_W-1:0] SPEED_MIN = SPEED_W'(1);

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_PLAUS_LO = 3'd0;
    localparam logic [2:0] REG_PLAUS_HI = 3'd1;
    localparam logic [2:0] REG_RANGE_LO = 3'd2;
    localparam logic [2:0] REG_RANGE_HI = 3'd3;
    localparam logic [2:0] REG_TOP_SPD  = 3'd4;

    localparam logic [RATE_W-1:0]  RST_PLAUS_LO = RATE_W'(30);
    localparam logic [RATE_W-1:0]  RST_PLAUS_HI = RATE_W'(240);
    localparam logic [RATE_W-1:0]  RST_RANGE_LO = RATE_W'(80);
    localparam logic [RATE_W-1:0]  RST_RANGE_HI = RATE_W'(160);
    localparam logic [SPEED_W-1:0] RST_TOP_SPD  = SPEED_W'(100);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_SUM       = 6'b000010,
        ST_DIV_MEAN  = 6'b000100,
        ST_MAP       = 6'b001000,
        ST_DIV_SPEED = 6'b010000,
        ST_DONE      = 6'b100000
    } state_t;

endpackage

// ----- src/hrfs_if.sv -----
// ----------------------------------------------------------------------------
// hrfs_if
// Valid/ready channels for the heart-rate items and the fan results.
// ----------------------------------------------------------------------------
interface hrfs_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [hrfs_pkg::RATE_W-1:0] heart_rate;

    modport source (output valid, output func, output heart_rate, input ready);
    modport sink   (input valid, input func, input heart_rate, output ready);
endinterface

interface hrfs_out_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic                        rate_valid;
    logic [hrfs_pkg::RATE_W-1:0]  raw_rate;
    logic [hrfs_pkg::RATE_W-1:0]  smoothed_rate;
    logic                        fan_on;
    logic [hrfs_pkg::SPEED_W-1:0] fan_speed;

    modport source (output valid, output accepted, output rate_valid, output raw_rate,
                    output smoothed_rate, output fan_on, output fan_speed, input ready);
    modport sink   (input valid, input accepted, input rate_valid, input raw_rate,
                    input smoothed_rate, input fan_on, input fan_speed, output ready);
endinterface

// ----- src/hrfs_div.sv -----
// ----------------------------------------------------------------------------
// hrfs_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrfs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  hrfs_pkg::div_req_t req,
    output hrfs_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [hrfs_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [hrfs_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [hrfs_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [hrfs_pkg::DVS_W-1:0]     dvs_reg, dvs_next;

    logic [hrfs_pkg::DVS_W:0]       rem_shift;
    logic [hrfs_pkg::DVS_W:0]       diff;
    logic                           fits;

    assign rem_shift = {rem_reg, quo_reg[hrfs_pkg::DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            rem_next = fits ? diff[hrfs_pkg::DVS_W-1:0] : rem_shift[hrfs_pkg::DVS_W-1:0];
            quo_next = {quo_reg[hrfs_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == hrfs_pkg::DIV_CNT_W'(hrfs_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- src/heart_rate_to_fan_speed.sv -----
// ----------------------------------------------------------------------------
// heart_rate_to_fan_speed
// Smooths heart-rate samples over a ring and maps the mean onto a fan target.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  in_ch     sink       valid/ready          func, heart_rate
//  out_ch    source     valid/ready          accepted, rate_valid, raw_rate,
//                                            smoothed_rate, fan_on, fan_speed
//  APB       slave      psel/penable/pwrite  paddr, pwdata, prdata (pready = 1)
//
//  A rejected sample or a disconnect goes from the accept straight to the final
//  load. An accepted sample whose mean lands inside the fan range is accepted,
//  summed one filled ring entry at a time, passed twice through the shared
//  divider (mean, then speed) around one mapping step, and then loaded as the
//  result. A mean off or above the range, or a collapsed range, skips the speed
//  pass.
//  Reset is asynchronous and active low; it returns the registers to their
//  defaults and empties the ring. A result held by a stalled out_ch does not
//  block the next input transaction; only the final load waits for it.
//
// ----------------------------------------------------------------------------
module heart_rate_to_fan_speed (
    input  logic                          clk,
    input  logic                          rst_n,
    hrfs_in_if.sink                       in_ch,
    hrfs_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hrfs_pkg::ADDR_W-1:0]   paddr,
    input  logic [hrfs_pkg::DATA_W-1:0]   pwdata,
    output logic [hrfs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [hrfs_pkg::RATE_W-1:0]  plaus_lo_reg;
    logic [hrfs_pkg::RATE_W-1:0]  plaus_hi_reg;
    logic [hrfs_pkg::RATE_W-1:0]  range_lo_reg;
    logic [hrfs_pkg::RATE_W-1:0]  range_hi_reg;
    logic [hrfs_pkg::SPEED_W-1:0] top_spd_reg;
    logic                         cfg_write;
    logic [2:0]                   reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[hrfs_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plaus_lo_reg <= hrfs_pkg::RST_PLAUS_LO;
            plaus_hi_reg <= hrfs_pkg::RST_PLAUS_HI;
            range_lo_reg <= hrfs_pkg::RST_RANGE_LO;
            range_hi_reg <= hrfs_pkg::RST_RANGE_HI;
            top_spd_reg  <= hrfs_pkg::RST_TOP_SPD;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                hrfs_pkg::REG_PLAUS_LO: plaus_lo_reg <= pwdata[hrfs_pkg::RATE_W-1:0];
                hrfs_pkg::REG_PLAUS_HI: plaus_hi_reg <= pwdata[hrfs_pkg::RATE_W-1:0];
                hrfs_pkg::REG_RANGE_LO: range_lo_reg <= pwdata[hrfs_pkg::RATE_W-1:0];
                hrfs_pkg::REG_RANGE_HI: range_hi_reg <= pwdata[hrfs_pkg::RATE_W-1:0];
                hrfs_pkg::REG_TOP_SPD:  top_spd_reg  <= pwdata[hrfs_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            hrfs_pkg::REG_PLAUS_LO: prdata = hrfs_pkg::DATA_W'(plaus_lo_reg);
            hrfs_pkg::REG_PLAUS_HI: prdata = hrfs_pkg::DATA_W'(plaus_hi_reg);
            hrfs_pkg::REG_RANGE_LO: prdata = hrfs_pkg::DATA_W'(range_lo_reg);
            hrfs_pkg::REG_RANGE_HI: prdata = hrfs_pkg::DATA_W'(range_hi_reg);
            hrfs_pkg::REG_TOP_SPD:  prdata = hrfs_pkg::DATA_W'(top_spd_reg);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Held state and sequencer registers.
    // ------------------------------------------------------------------
    hrfs_pkg::state_t             state_reg, state_next;
    logic [hrfs_pkg::IDX_W-1:0]   slot_reg, slot_next;
    logic [hrfs_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic                         valid_flag_reg, valid_flag_next;
    logic [hrfs_pkg::RATE_W-1:0]  raw_reg, raw_next;
    logic [hrfs_pkg::RATE_W-1:0]  smoothed_reg, smoothed_next;
    logic                         power_reg, power_next;
    logic [hrfs_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic                         acc_reg, acc_next;
    logic [hrfs_pkg::IDX_W-1:0]   k_reg, k_next;
    logic [hrfs_pkg::SUM_W-1:0]   sum_reg, sum_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_acc_reg, out_rvalid_reg, out_on_reg;
    logic [hrfs_pkg::RATE_W-1:0]  out_raw_reg, out_smooth_reg;
    logic [hrfs_pkg::SPEED_W-1:0] out_speed_reg;
    logic                         out_load;

    // The ring is only ever read over slots below the fill count, and those
    // were all written since the last clear, so it needs no reset.
    logic [hrfs_pkg::RATE_W-1:0]  ring [hrfs_pkg::SMOOTH_DEPTH];
    logic                         ring_we;

    hrfs_pkg::div_req_t           div_req;
    hrfs_pkg::div_rsp_t           div_rsp;

    hrfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Datapath helpers.
    // ------------------------------------------------------------------
    logic                         in_fire;
    logic                         plausible;
    logic [hrfs_pkg::SUM_W-1:0]   sum_add;
    logic                         sum_last;
    logic [hrfs_pkg::SPEED_W-1:0] top_sat;
    logic                         map_off;
    logic                         map_above;
    logic [hrfs_pkg::RATE_W-1:0]  span;
    logic [hrfs_pkg::RATE_W-1:0]  offset;
    logic [hrfs_pkg::DIV_W-1:0]   product;
    logic [hrfs_pkg::SPEED_W-1:0] speed_div;

    assign in_ch.ready = (state_reg == hrfs_pkg::ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign plausible   = (in_ch.heart_rate >= plaus_lo_reg) &&
                         (in_ch.heart_rate <= plaus_hi_reg);

    assign sum_add  = sum_reg + hrfs_pkg::SUM_W'(ring[k_reg]);
    assign sum_last = (hrfs_pkg::CNT_W'(k_reg) == fill_reg - 1'b1);

    // Top speed is saturated into its legal window before any use.
    always_comb
    begin
        priority if (top_spd_reg < hrfs_pkg::SPEED_MIN)
            top_sat = hrfs_pkg::SPEED_MIN;
        else if (top_spd_reg > hrfs_pkg::SPEED_MAX)
            top_sat = hrfs_pkg::SPEED_MAX;
        else
            top_sat = top_spd_reg;
    end

    // A zero mean only arises with a zero plausible floor and counts as off.
    assign map_off   = (smoothed_reg == '0) || (smoothed_reg < range_lo_reg);
    assign map_above = (smoothed_reg > range_hi_reg);
    assign span      = range_hi_reg - range_lo_reg;
    assign offset    = smoothed_reg - range_lo_reg;
    assign product   = hrfs_pkg::DIV_W'(offset) * hrfs_pkg::DIV_W'(top_sat);

    // The quotient never exceeds top speed in practice, but clamp anyway and
    // floor a zero result at the minimum running speed.
    always_comb
    begin
        priority if (div_rsp.quotient > hrfs_pkg::DIV_W'(top_sat))
            speed_div = top_sat;
        else if (div_rsp.quotient == '0)
            speed_div = hrfs_pkg::SPEED_MIN;
        else
            speed_div = div_rsp.quotient[hrfs_pkg::SPEED_W-1:0];
    end

    assign out_load = (state_reg == hrfs_pkg::ST_DONE) && (!out_valid_reg || out_ch.ready);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        valid_flag_next = valid_flag_reg;
        raw_next        = raw_reg;
        smoothed_next   = smoothed_reg;
        power_next      = power_reg;
        speed_next      = speed_reg;
        acc_next        = acc_reg;
        k_next          = k_reg;
        sum_next        = sum_reg;
        ring_we         = 1'b0;
        div_req         = '0;

        unique case (state_reg)
            hrfs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (in_ch.func)
                    begin
                        // Sensor lost: drop the ring and all held rates.
                        slot_next       = '0;
                        fill_next       = '0;
                        valid_flag_next = 1'b0;
                        raw_next        = '0;
                        smoothed_next   = '0;
                        power_next      = 1'b0;
                        speed_next      = '0;
                        acc_next        = 1'b0;
                        state_next      = hrfs_pkg::ST_DONE;
                    end
                    else if (plausible)
                    begin
                        ring_we         = 1'b1;
                        acc_next        = 1'b1;
                        raw_next        = in_ch.heart_rate;
                        valid_flag_next = 1'b1;
                        if (slot_reg == hrfs_pkg::IDX_W'(hrfs_pkg::SMOOTH_DEPTH - 1))
                            slot_next = '0;
                        else
                            slot_next = slot_reg + 1'b1;
                        if (fill_reg < hrfs_pkg::CNT_W'(hrfs_pkg::SMOOTH_DEPTH))
                            fill_next = fill_reg + 1'b1;
                        k_next     = '0;
                        sum_next   = '0;
                        state_next = hrfs_pkg::ST_SUM;
                    end
                    else
                    begin
                        // Implausible sample: report the held state unchanged.
                        acc_next   = 1'b0;
                        state_next = hrfs_pkg::ST_DONE;
                    end
                end
            end

            hrfs_pkg::ST_SUM:
            begin
                if (sum_last)
                begin
                    // Rounded mean: (sum + fill/2) / fill.
                    div_req.start    = 1'b1;
                    div_req.dividend = hrfs_pkg::DIV_W'(sum_add) +
                                       hrfs_pkg::DIV_W'(fill_reg >> 1);
                    div_req.divisor  = hrfs_pkg::DVS_W'(fill_reg);
                    state_next       = hrfs_pkg::ST_DIV_MEAN;
                end
                else
                begin
                    sum_next = sum_add;
                    k_next   = k_reg + 1'b1;
                end
            end

            hrfs_pkg::ST_DIV_MEAN:
            begin
                if (div_rsp.done)
                begin
                    smoothed_next = div_rsp.quotient[hrfs_pkg::RATE_W-1:0];
                    state_next    = hrfs_pkg::ST_MAP;
                end
            end

            hrfs_pkg::ST_MAP:
            begin
                priority if (map_off)
                begin
                    power_next = 1'b0;
                    speed_next = '0;
                    state_next = hrfs_pkg::ST_DONE;
                end
                else if (map_above || span == '0)
                begin
                    // Above the range, or a collapsed range: full speed.
                    power_next = 1'b1;
                    speed_next = top_sat;
                    state_next = hrfs_pkg::ST_DONE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = product;
                    div_req.divisor  = span;
                    state_next       = hrfs_pkg::ST_DIV_SPEED;
                end
            end

            hrfs_pkg::ST_DIV_SPEED:
            begin
                if (div_rsp.done)
                begin
                    power_next = 1'b1;
                    speed_next = speed_div;
                    state_next = hrfs_pkg::ST_DONE;
                end
            end

            hrfs_pkg::ST_DONE:
            begin
                if (out_load)
                    state_next = hrfs_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = hrfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hrfs_pkg::ST_IDLE;
            slot_reg       <= '0;
            fill_reg       <= '0;
            valid_flag_reg <= 1'b0;
            raw_reg        <= '0;
            smoothed_reg   <= '0;
            power_reg      <= 1'b0;
            speed_reg      <= '0;
            acc_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            fill_reg       <= fill_next;
            valid_flag_reg <= valid_flag_next;
            raw_reg        <= raw_next;
            smoothed_reg   <= smoothed_next;
            power_reg      <= power_next;
            speed_reg      <= speed_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        sum_reg <= sum_next;
        if (ring_we)
            ring[slot_reg] <= in_ch.heart_rate;
        if (out_load)
        begin
            out_acc_reg    <= acc_reg;
            out_rvalid_reg <= valid_flag_reg;
            out_raw_reg    <= raw_reg;
            out_smooth_reg <= smoothed_reg;
            out_on_reg     <= power_reg;
            out_speed_reg  <= speed_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.accepted      = out_acc_reg;
    assign out_ch.rate_valid    = out_rvalid_reg;
    assign out_ch.raw_rate      = out_raw_reg;
    assign out_ch.smoothed_rate = out_smooth_reg;
    assign out_ch.fan_on        = out_on_reg;
    assign out_ch.fan_speed     = out_speed_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= hrfs_pkg::CNT_W'(hrfs_pkg::SMOOTH_DEPTH))
        else $error("fill count exceeds ring depth");

    a_valid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        valid_flag_reg == (fill_reg != '0))
        else $error("valid flag disagrees with ring fill");

    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.fan_on |-> out_ch.fan_speed == '0)
        else $error("fan off with nonzero speed");

    a_on_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.fan_on |->
            out_ch.fan_speed != '0 && out_ch.fan_speed <= hrfs_pkg::SPEED_MAX)
        else $error("fan on with speed out of range");

    a_acc_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.accepted |-> out_ch.rate_valid)
        else $error("accepted sample without a valid rate");

endmodule

// ----- verif/heart_rate_to_fan_speed_tb.sv -----
// ----------------------------------------------------------------------------
// heart_rate_to_fan_speed_tb
// Self-checking testbench for the heart-rate to fan-speed block. It sends
// heart-rate samples and disconnect events over the input channel. It
// predicts the fan target of every input transaction and compares each
// output transaction with the oldest prediction. Register settings are
// changed over the APB port between bursts of traffic.
// ----------------------------------------------------------------------------
module heart_rate_to_fan_speed_tb;

    import hrfs_pkg::*;

    // Longest run of cycles without any transaction before the run is abandoned.
    // The worst honest case is a long receiver hold-off plus one full ring update.
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned IDLE_PERCENT = 20;

    // One result of the block, in the order of the output fields.
    typedef struct packed {
        logic                accepted;
        logic                rate_valid;
        logic [RATE_W-1:0]   raw_rate;
        logic [RATE_W-1:0]   smoothed_rate;
        logic                fan_on;
        logic [SPEED_W-1:0]  fan_speed;
    } fan_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    hrfs_in_if  in_ch ();
    hrfs_out_if out_ch ();

    heart_rate_to_fan_speed u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the registers and of the smoothing state.
    // ------------------------------------------------------------------------
    logic [RATE_W-1:0]  cfg_plaus_lo = RST_PLAUS_LO;
    logic [RATE_W-1:0]  cfg_plaus_hi = RST_PLAUS_HI;
    logic [RATE_W-1:0]  cfg_range_lo = RST_RANGE_LO;
    logic [RATE_W-1:0]  cfg_range_hi = RST_RANGE_HI;
    logic [SPEED_W-1:0] cfg_top      = RST_TOP_SPD;

    logic [RATE_W-1:0]  hist_ring [SMOOTH_DEPTH];
    int unsigned        hist_slot;
    int unsigned        hist_fill;
    logic               have_rate;
    logic [RATE_W-1:0]  held_raw;
    logic [RATE_W-1:0]  held_mean;
    logic               held_on;
    logic [SPEED_W-1:0] held_speed;

    // Fan targets predicted for accepted input transactions, oldest first.
    fan_result_t pending_targets [$];

    int unsigned failures     = 0;
    int unsigned idle_cycles  = 0;
    bit          gaps_on      = 1'b1;
    int unsigned hold_request = 0;

    function automatic void clear_history();
        for (int k = 0; k < SMOOTH_DEPTH; k++)
            hist_ring[k] = '0;
        hist_slot  = 0;
        hist_fill  = 0;
        have_rate  = 1'b0;
        held_raw   = '0;
        held_mean  = '0;
        held_on    = 1'b0;
        held_speed = '0;
    endfunction

    // Advances the shadow state by one item and returns the fan target that
    // the block must report for it.
    function automatic fan_result_t step_fan_target(input logic disc,
                                                    input logic [RATE_W-1:0] hr);
        int unsigned sum;
        int unsigned mean;
        int unsigned top;
        int unsigned span;
        int unsigned spd;
        fan_result_t res;
        res = '0;
        if (disc)
        begin
            clear_history();
        end
        else if (hr >= cfg_plaus_lo && hr <= cfg_plaus_hi)
        begin
            res.accepted = 1'b1;
            held_raw     = hr;
            have_rate    = 1'b1;
            hist_ring[hist_slot] = hr;
            hist_slot = (hist_slot + 1) % SMOOTH_DEPTH;
            if (hist_fill < SMOOTH_DEPTH)
                hist_fill++;

            // Rounded mean over the filled slots; filling always starts at slot 0.
            sum = 0;
            for (int k = 0; k < hist_fill; k++)
                sum += hist_ring[k];
            mean      = (sum + hist_fill / 2) / hist_fill;
            held_mean = RATE_W'(mean);

            // A top speed outside 1..100 is pulled back into that range.
            top = cfg_top;
            if (top < 1)
                top = 1;
            if (top > 100)
                top = 100;

            if (held_mean == 0 || held_mean < cfg_range_lo)
            begin
                held_on    = 1'b0;
                held_speed = '0;
            end
            else if (held_mean <= cfg_range_hi)
            begin
                span = cfg_range_hi - cfg_range_lo;
                if (span == 0)
                begin
                    spd = top;
                end
                else
                begin
                    spd = ((held_mean - cfg_range_lo) * top) / span;
                    if (spd > top)
                        spd = top;
                    if (spd == 0)
                        spd = 1;
                end
                held_on    = 1'b1;
                held_speed = SPEED_W'(spd);
            end
            else
            begin
                // Above the range, and every case of an inverted range that is
                // not below range_low, runs at top speed.
                held_on    = 1'b1;
                held_speed = SPEED_W'(top);
            end
        end
        res.rate_valid    = have_rate;
        res.raw_rate      = held_raw;
        res.smoothed_rate = held_mean;
        res.fan_on        = held_on;
        res.fan_speed     = held_speed;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: checks each output transaction and drives ready, with
    // random idle cycles and, on request, one long hold-off.
    // ------------------------------------------------------------------------
    task automatic check_fan_result();
        fan_result_t want;
        if (pending_targets.size() == 0)
        begin
            $error("unexpected result: accepted=%0d speed=%0d",
                   out_ch.accepted, out_ch.fan_speed);
            failures++;
            return;
        end
        want = pending_targets.pop_front();
        if (out_ch.accepted !== want.accepted)
        begin
            $error("accepted: expected %0d, got %0d", want.accepted, out_ch.accepted);
            failures++;
        end
        if (out_ch.rate_valid !== want.rate_valid)
        begin
            $error("rate_valid: expected %0d, got %0d", want.rate_valid, out_ch.rate_valid);
            failures++;
        end
        if (out_ch.raw_rate !== want.raw_rate)
        begin
            $error("raw_rate: expected %0d, got %0d", want.raw_rate, out_ch.raw_rate);
            failures++;
        end
        if (out_ch.smoothed_rate !== want.smoothed_rate)
        begin
            $error("smoothed_rate: expected %0d, got %0d",
                   want.smoothed_rate, out_ch.smoothed_rate);
            failures++;
        end
        if (out_ch.fan_on !== want.fan_on)
        begin
            $error("fan_on: expected %0d, got %0d", want.fan_on, out_ch.fan_on);
            failures++;
        end
        if (out_ch.fan_speed !== want.fan_speed)
        begin
            $error("fan_speed: expected %0d, got %0d", want.fan_speed, out_ch.fan_speed);
            failures++;
        end
    endtask

    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                check_fan_result();
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(99, 0) < IDLE_PERCENT)
            begin
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run of cycles with no transaction on either channel means
    // the block has hung.
    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------

    // Offers one item and returns at the edge where the transaction happens.
    // Valid stays high afterwards so that back-to-back items need no gap.
    task automatic send_reading(input logic disc, input logic [RATE_W-1:0] hr);
        while (gaps_on && $urandom_range(99, 0) < IDLE_PERCENT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= disc;
        in_ch.heart_rate <= hr;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        pending_targets.push_back(step_fan_target(disc, hr));
    endtask

    // Stops offering items and waits until every predicted result has arrived.
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (pending_targets.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // One APB write: a setup cycle, then an access cycle that ends at the edge
    // where pready is seen high. The strobes are lowered by the caller.
    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (idx)
            REG_PLAUS_LO: cfg_plaus_lo = value[RATE_W-1:0];
            REG_PLAUS_HI: cfg_plaus_hi = value[RATE_W-1:0];
            REG_RANGE_LO: cfg_range_lo = value[RATE_W-1:0];
            REG_RANGE_HI: cfg_range_hi = value[RATE_W-1:0];
            REG_TOP_SPD:  cfg_top      = value[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    // Rewrites every register once the block has gone idle.
    task automatic set_ranges(input int unsigned plo, input int unsigned phi,
                              input int unsigned rlo, input int unsigned rhi,
                              input int unsigned top);
        settle_block();
        write_reg(REG_PLAUS_LO, DATA_W'(plo));
        write_reg(REG_PLAUS_HI, DATA_W'(phi));
        write_reg(REG_RANGE_LO, DATA_W'(rlo));
        write_reg(REG_RANGE_HI, DATA_W'(rhi));
        write_reg(REG_TOP_SPD,  DATA_W'(top));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random traffic shaped like a real sensor: a heart-rate level that holds
    // for a while with a little jitter, so that the mean walks across the whole
    // fan range. Some items sit right on the window edges, some are noise, and
    // a few are disconnects.
    task automatic run_burst(input int unsigned count);
        int lo;
        int hi;
        int hr_level;
        int hr;
        int unsigned pick;
        if (cfg_plaus_lo <= cfg_plaus_hi)
        begin
            lo = cfg_plaus_lo;
            hi = cfg_plaus_hi;
        end
        else
        begin
            lo = 0;
            hi = 511;
        end
        hr_level = $urandom_range(hi, lo);
        for (int unsigned n = 0; n < count; n++)
        begin
            if ($urandom_range(31, 0) == 0)
                hr_level = $urandom_range(hi, lo);
            pick = $urandom_range(99, 0);
            if (pick < 3)
            begin
                send_reading(1'b1, RATE_W'($urandom_range(511, 0)));
            end
            else if (pick < 13)
            begin
                send_reading(1'b0, RATE_W'($urandom_range(511, 0)));
            end
            else if (pick < 17)
            begin
                // Just outside or just on one of the window edges.
                case ($urandom_range(3, 0))
                    0: hr = lo - 1;
                    1: hr = lo;
                    2: hr = hi;
                    default: hr = hi + 1;
                endcase
                if (hr < 0)
                    hr = 0;
                if (hr > 511)
                    hr = 511;
                send_reading(1'b0, RATE_W'(hr));
            end
            else
            begin
                hr = hr_level + int'($urandom_range(8, 0)) - 4;
                if (hr < lo)
                    hr = lo;
                if (hr > hi)
                    hr = hi;
                send_reading(1'b0, RATE_W'(hr));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset settings: window edges, filling the ring past its depth so that
    // it wraps, the fan off and inside the range, the floor of one at the
    // bottom of the range, and disconnects in between.
    task automatic test_default_settings();
        logic [RATE_W-1:0] rates [14];
        rates = '{9'd0, 9'd29, 9'd30, 9'd240, 9'd241, 9'd511, 9'd160,
                  9'd120, 9'd100, 9'd90, 9'd85, 9'd200, 9'd200, 9'd200};
        foreach (rates[k])
            send_reading(1'b0, rates[k]);
        send_reading(1'b1, 9'd0);
        send_reading(1'b0, 9'd81);
        send_reading(1'b1, 9'd0);
        send_reading(1'b0, 9'd80);
        send_reading(1'b1, 9'd511);
    endtask

    // Extreme register settings: a full window with a zero rate, top speed
    // above and below its range, equal range bounds, an inverted range, an
    // empty window and a window of a single value.
    task automatic test_register_corners();
        set_ranges(0, 511, 0, 511, 127);
        send_reading(1'b1, 9'd0);
        send_reading(1'b0, 9'd0);
        run_burst(40);
        set_ranges(0, 511, 100, 100, 0);
        run_burst(40);
        set_ranges(30, 240, 200, 100, 50);
        run_burst(40);
        set_ranges(511, 0, 80, 160, 1);
        run_burst(40);
        set_ranges(0, 511, 0, 0, 100);
        run_burst(40);
        set_ranges(511, 511, 511, 511, 100);
        run_burst(40);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items back to back, so the block must stall its input.
    task automatic test_output_stall();
        set_ranges(30, 240, 80, 160, 100);
        gaps_on      = 1'b0;
        hold_request = HOLD_CYCLES;
        run_burst(12);
        settle_block();
        gaps_on = 1'b1;
    endtask

    // Bursts of random traffic under changing settings. Most settings are
    // sensible; the rest are fully random. One burst runs without idle cycles.
    task automatic test_random_traffic();
        int unsigned rlo;
        for (int unsigned phase = 0; phase < 11; phase++)
        begin
            if ($urandom_range(9, 0) < 7)
            begin
                rlo = $urandom_range(150, 40);
                set_ranges($urandom_range(60, 0), $urandom_range(511, 150),
                           rlo, $urandom_range(250, rlo), $urandom_range(100, 1));
            end
            else
            begin
                set_ranges($urandom_range(511, 0), $urandom_range(511, 0),
                           $urandom_range(511, 0), $urandom_range(511, 0),
                           $urandom_range(127, 0));
            end
            gaps_on = (phase != 4);
            run_burst(150);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        clear_history();
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.func       <= 1'b0;
        in_ch.heart_rate <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_settings();
        test_register_corners();
        test_output_stall();
        test_random_traffic();

        // Let every predicted result arrive, then give the block time to show
        // any stray result it might still produce.
        settle_block();
        repeat (60) @(posedge clk);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/hrfs_pkg.sv
src/hrfs_if.sv
src/hrfs_div.sv
src/heart_rate_to_fan_speed.sv
verif/heart_rate_to_fan_speed_tb.sv
